FILE: design/spi_frame_port_with_fifos_defines.svh
// Assertion helpers used by the top-level design file.
`ifndef SPI_FRAME_PORT_WITH_FIFOS_DEFINES_SVH
`define SPI_FRAME_PORT_WITH_FIFOS_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define SFP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define SFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sfp_pkg.sv
`timescale 1ns / 1ps

package sfp_pkg;

  // Default FIFO depth in frames
  localparam int unsigned DefFifoDepth = 16;
  // Frame read when no client drives MISO
  localparam logic [7:0] PullupFrame = 8'hFF;
  // Most results one command can cause
  localparam int unsigned MaxRes = 3;

  typedef enum logic [2:0] {
    CMD_PUSH     = 3'd0,
    CMD_POP      = 3'd1,
    CMD_CANCEL   = 3'd2,
    CMD_TICK     = 3'd3,
    CMD_CL_START = 3'd4,
    CMD_CL_END   = 3'd5,
    CMD_SET_SEL  = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    EV_ACK        = 3'd0,
    EV_HOST_START = 3'd1,
    EV_HOST_DONE  = 3'd2,
    EV_CL_START   = 3'd3,
    EV_CL_DONE    = 3'd4,
    EV_RX_DATA    = 3'd5,
    EV_END_CLIENT = 3'd6
  } ev_e;

  typedef enum logic [1:0] {
    CFG_HOST_MODE   = 2'd0,
    CFG_FRAME_DELAY = 2'd1,
    CFG_TX_LIMIT    = 2'd2,
    CFG_RX_LIMIT    = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } st_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data_in;
    logic       flag_in;
    logic       client_present;
    logic [7:0] client_miso;
  } sfp_in_t;

  typedef struct packed {
    ev_e        event_res;
    logic [7:0] mosi;
    logic [7:0] miso;
    logic       ok;
    logic [7:0] rx_data;
    logic       last;
  } sfp_out_t;

endpackage

FILE: design/sfp_fifo_mem.sv
`timescale 1ns / 1ps

// Frame store: one write port, one read port with registered data.
module sfp_fifo_mem #(
  parameter int unsigned Depth = sfp_pkg::DefFifoDepth
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/spi_frame_port_with_fifos.sv
`timescale 1ns / 1ps
`include "spi_frame_port_with_fifos_defines.svh"

// Channel   | Ports                           | Transfer
// ----------+---------------------------------+----------------------------------
// command   | start, busy, item_i             | start high while busy low
// result    | strobe_o, res_o                 | every cycle strobe_o is high
// config    | cfg_we_i, cfg_idx_i, cfg_wdata_i | every cycle cfg_we_i is high
//
// A command yields n = 1..3 results. In the EXEC state the TX and
// RX frame memories return the head entries and the FIFO state is updated;
// then the results, one per cycle, in order, with last on the final one.
// A new command is taken in the cycle of the final result.
// Reset (rst_ni, async, active low) clears pointers, counts, flags and the
// FSM; the frame memories are not cleared. Results cannot be stalled.
module spi_frame_port_with_fifos #(
  parameter int unsigned FifoDepth = sfp_pkg::DefFifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  sfp_pkg::sfp_in_t item_i,
  output logic             strobe_o,
  output sfp_pkg::sfp_out_t res_o,
  input  logic             cfg_we_i,
  input  sfp_pkg::cfg_e    cfg_idx_i,
  input  logic [15:0]      cfg_wdata_i
);

  import sfp_pkg::*;

  localparam int unsigned PW = $clog2(FifoDepth);
  localparam logic [PW:0] DepthW = FifoDepth[PW:0];

  // Wrap a sum below twice the depth back into the pointer range
  function automatic logic [PW-1:0] wrap(input logic [PW:0] s);
    logic [PW:0] t;
    t = (s >= DepthW) ? (s - DepthW) : s;
    return t[PW-1:0];
  endfunction

  // Capacity from a limit register; zero or oversize means full depth
  function automatic logic [PW:0] cap_of(input logic [4:0] lim);
    logic [PW:0] c;
    if (lim == 5'd0 || int'(lim) > int'(FifoDepth)) begin
      c = DepthW;
    end else begin
      c = (PW+1)'(lim);
    end
    return c;
  endfunction

  function automatic sfp_out_t mk_res(input ev_e ev, input logic [7:0] mo,
                                      input logic [7:0] mi, input logic okv,
                                      input logic [7:0] rx);
    sfp_out_t r;
    r.event_res = ev;
    r.mosi      = mo;
    r.miso      = mi;
    r.ok        = okv;
    r.rx_data   = rx;
    r.last      = 1'b0;
    return r;
  endfunction

  // Configuration registers
  logic        host_mode_q;
  logic [15:0] frame_delay_q;
  logic [4:0]  tx_limit_q, rx_limit_q;

  // FIFO and port state
  logic [PW-1:0] tx_head_q, tx_head_d, rx_head_q, rx_head_d;
  logic [PW:0]   tx_cnt_q, tx_cnt_d, rx_cnt_q, rx_cnt_d;
  logic          hbusy_q, hbusy_d;
  logic [15:0]   ticks_q, ticks_d;
  logic          att_q, att_d;
  logic          sel_q, sel_d;
  logic [7:0]    shift_q, shift_d;

  // Sequencer
  st_e       state_q, state_d;
  sfp_in_t   item_q;
  sfp_out_t  res_q [MaxRes];
  sfp_out_t  res_d [MaxRes];
  logic [1:0] res_k_q, res_k_d;
  logic      accept;
  sfp_out_t  cur_res;

  // Memory ports
  logic          tx_we, rx_we;
  logic [PW-1:0] tx_waddr, rx_waddr;
  logic [7:0]    tx_wdata, rx_wdata, tx_rdata, rx_rdata;

  sfp_fifo_mem #(.Depth(FifoDepth)) u_tx_mem (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (tx_wdata),
    .re_i    (accept),
    .raddr_i (tx_head_q),
    .rdata_o (tx_rdata)
  );

  sfp_fifo_mem #(.Depth(FifoDepth)) u_rx_mem (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (rx_wdata),
    .re_i    (accept),
    .raddr_i (rx_head_q),
    .rdata_o (rx_rdata)
  );

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_mode_q   <= 1'b0;
      frame_delay_q <= 16'd1;
      tx_limit_q    <= 5'd0;
      rx_limit_q    <= 5'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HOST_MODE:   host_mode_q   <= cfg_wdata_i[0];
        CFG_FRAME_DELAY: frame_delay_q <= cfg_wdata_i;
        CFG_TX_LIMIT:    tx_limit_q    <= cfg_wdata_i[4:0];
        CFG_RX_LIMIT:    rx_limit_q    <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // Handshake and result output
  assign cur_res  = res_q[res_k_q];
  assign res_o    = cur_res;
  assign strobe_o = (state_q == ST_EMIT);
  assign busy     = (state_q == ST_EXEC) || ((state_q == ST_EMIT) && !cur_res.last);
  assign accept   = start && !busy;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    res_k_d = res_k_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_EMIT;
        res_k_d = 2'd0;
      end
      ST_EMIT: begin
        if (cur_res.last) begin
          state_d = accept ? ST_EXEC : ST_IDLE;
        end else begin
          res_k_d = res_k_q + 2'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command execution: read-modify-write of the FIFO state
  always_comb begin
    logic [PW:0]   tx_cap, rx_cap, rc;
    logic [PW-1:0] rh;
    logic [15:0]   ticks_dec, delay_eff;
    logic          hs_go, rxp_go;
    logic [7:0]    rxp_val, mo, mi, rxv;
    logic [1:0]    n;

    tx_head_d = tx_head_q;
    tx_cnt_d  = tx_cnt_q;
    rx_head_d = rx_head_q;
    rx_cnt_d  = rx_cnt_q;
    hbusy_d   = hbusy_q;
    ticks_d   = ticks_q;
    att_d     = att_q;
    sel_d     = sel_q;
    shift_d   = shift_q;
    tx_we     = 1'b0;
    tx_waddr  = tx_head_q;
    tx_wdata  = item_q.data_in;
    rx_we     = 1'b0;
    rx_waddr  = rx_head_q;
    rx_wdata  = 8'd0;
    for (int i = 0; i < MaxRes; i++) res_d[i] = res_q[i];

    tx_cap    = cap_of(tx_limit_q);
    rx_cap    = cap_of(rx_limit_q);
    ticks_dec = ticks_q - 16'd1;
    delay_eff = (frame_delay_q == 16'd0) ? 16'd1 : frame_delay_q;
    hs_go     = 1'b0;
    rxp_go    = 1'b0;
    rxp_val   = 8'd0;
    mo        = tx_rdata;
    mi        = 8'd0;
    rxv       = 8'd0;
    rc        = '0;
    rh        = '0;
    n         = 2'd0;

    if (state_q == ST_EXEC) begin
      for (int i = 0; i < MaxRes; i++) res_d[i] = '0;

      case (item_q.cmd)
        CMD_PUSH: begin
          if (tx_cnt_q < tx_cap) begin
            tx_we    = 1'b1;
            tx_waddr = wrap({1'b0, tx_head_q} + tx_cnt_q);
            tx_cnt_d = tx_cnt_q + 1'b1;
            if (host_mode_q && !hbusy_q) begin
              hs_go = 1'b1;
              // empty FIFO: the frame just written is the head
              if (tx_cnt_q == '0) mo = item_q.data_in;
            end
          end
        end
        CMD_POP: begin
          if (rx_cnt_q != '0) begin
            rxv       = rx_rdata;
            rx_head_d = wrap({1'b0, rx_head_q} + 1'b1);
            rx_cnt_d  = rx_cnt_q - 1'b1;
          end
          res_d[n] = mk_res(EV_RX_DATA, 8'd0, 8'd0, 1'b0, rxv);
          n = n + 2'd1;
        end
        CMD_CANCEL: begin
          tx_head_d = '0;
          tx_cnt_d  = '0;
          if (host_mode_q && hbusy_q) begin
            res_d[n] = mk_res(EV_HOST_DONE, 8'd0, 8'd0, 1'b0, 8'd0);
            n = n + 2'd1;
            hbusy_d = 1'b0;
            if (rx_cnt_q != '0) rx_cnt_d = rx_cnt_q - 1'b1;
            ticks_d = 16'd0;
            if (att_q) begin
              res_d[n] = mk_res(EV_END_CLIENT, 8'd0, 8'd0, 1'b0, 8'd0);
              n = n + 2'd1;
              att_d = 1'b0;
            end
          end
        end
        CMD_TICK: begin
          if (ticks_q != 16'd0) begin
            ticks_d = ticks_dec;
            if (ticks_dec == 16'd0) begin
              if (att_q) begin
                res_d[n] = mk_res(EV_END_CLIENT, 8'd0, 8'd0, 1'b1, 8'd0);
                n = n + 2'd1;
                att_d = 1'b0;
              end
              res_d[n] = mk_res(EV_HOST_DONE, 8'd0, 8'd0, 1'b1, 8'd0);
              n = n + 2'd1;
              // chain the next queued frame
              if (tx_cnt_q != '0) hs_go = 1'b1;
              else hbusy_d = 1'b0;
            end
          end
        end
        CMD_CL_START: begin
          if (host_mode_q || !sel_q || hbusy_q) begin
            res_d[n] = mk_res(EV_ACK, 8'd0, PullupFrame, 1'b0, 8'd0);
            n = n + 2'd1;
          end else begin
            hbusy_d = 1'b1;
            if (tx_cnt_q != '0) begin
              mi        = tx_rdata;
              tx_head_d = wrap({1'b0, tx_head_q} + 1'b1);
              tx_cnt_d  = tx_cnt_q - 1'b1;
            end else begin
              mi = shift_q;
            end
            shift_d  = item_q.data_in;
            res_d[n] = mk_res(EV_CL_START, item_q.data_in, mi, 1'b0, 8'd0);
            n = n + 2'd1;
          end
        end
        CMD_CL_END: begin
          if (hbusy_q) begin
            hbusy_d = 1'b0;
            if (item_q.flag_in) begin
              rxp_go  = 1'b1;
              rxp_val = shift_q;
            end
            res_d[n] = mk_res(EV_CL_DONE, 8'd0, 8'd0, item_q.flag_in, 8'd0);
            n = n + 2'd1;
          end
        end
        CMD_SET_SEL: sel_d = item_q.flag_in;
        default: ;
      endcase

      // Host frame start: pop TX head, sample MISO, restart timer
      if (hs_go) begin
        tx_head_d = wrap({1'b0, tx_head_q} + 1'b1);
        tx_cnt_d  = tx_cnt_d - 1'b1;
        att_d     = item_q.client_present;
        mi        = item_q.client_present ? item_q.client_miso : PullupFrame;
        res_d[n]  = mk_res(EV_HOST_START, mo, mi, 1'b0, 8'd0);
        n = n + 2'd1;
        rxp_go    = 1'b1;
        rxp_val   = mi;
        hbusy_d   = 1'b1;
        ticks_d   = delay_eff;
      end

      // RX write; oldest frames go when over capacity
      if (rxp_go) begin
        rh = rx_head_d;
        rc = rx_cnt_d;
        if (rc == DepthW) begin
          rh = wrap({1'b0, rh} + 1'b1);
          rc = rc - 1'b1;
        end
        rx_we    = 1'b1;
        rx_waddr = wrap({1'b0, rh} + rc);
        rx_wdata = rxp_val;
        rc = rc + 1'b1;
        if (rc > rx_cap) begin
          rh = wrap({1'b0, rh} + (rc - rx_cap));
          rc = rx_cap;
        end
        rx_head_d = rh;
        rx_cnt_d  = rc;
      end

      // Nothing to report: plain ack
      if (n == 2'd0) begin
        res_d[0] = mk_res(EV_ACK, 8'd0, 8'd0, 1'b0, 8'd0);
        n = 2'd1;
      end
      res_d[n - 2'd1].last = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      res_k_q   <= 2'd0;
      tx_head_q <= '0;
      tx_cnt_q  <= '0;
      rx_head_q <= '0;
      rx_cnt_q  <= '0;
      hbusy_q   <= 1'b0;
      ticks_q   <= 16'd0;
      att_q     <= 1'b0;
      sel_q     <= 1'b0;
      shift_q   <= 8'd0;
    end else begin
      state_q   <= state_d;
      res_k_q   <= res_k_d;
      tx_head_q <= tx_head_d;
      tx_cnt_q  <= tx_cnt_d;
      rx_head_q <= rx_head_d;
      rx_cnt_q  <= rx_cnt_d;
      hbusy_q   <= hbusy_d;
      ticks_q   <= ticks_d;
      att_q     <= att_d;
      sel_q     <= sel_d;
      shift_q   <= shift_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_i;
    for (int i = 0; i < MaxRes; i++) res_q[i] <= res_d[i];
  end

  `SFP_ASSERT_ALWAYS(a_tx_cnt_range, tx_cnt_q <= DepthW, "TX count beyond depth")
  `SFP_ASSERT_ALWAYS(a_rx_cnt_range, rx_cnt_q <= DepthW, "RX count beyond depth")
  `SFP_ASSERT_NEXT(a_accept_exec, start && !busy, state_q == ST_EXEC, "accepted command not run")
  `SFP_ASSERT_NEXT(a_last_ends, strobe_o && res_o.last, !strobe_o, "result after last")

endmodule
